/* rtl/core/rclfr_pkg.sv */
// Shared types, constants and functions of the radio-control link frame receiver.
package rclfr_pkg;

   localparam int BufferBytes  = 64;
   localparam int ChannelCount = 16;
   localparam int ChannelWidth = 11;

   localparam logic [7:0] SYNC_A         = 8'hC8;
   localparam logic [7:0] SYNC_B         = 8'hEE;
   localparam logic [7:0] TYPE_CHANNELS  = 8'h16;
   localparam logic [7:0] TYPE_LINKSTATS = 8'h14;
   localparam logic [7:0] LEN_MIN        = 8'd2;
   localparam logic [7:0] LEN_MAX        = 8'd62;
   localparam logic [7:0] CRC_POLY       = 8'hD5;

   localparam logic [2:0] CSR_FAILSAFE_EN = 3'd0;
   localparam logic [2:0] CSR_QUALITY_TH  = 3'd1;
   localparam logic [2:0] CSR_RSSI_TH     = 3'd2;
   localparam logic [2:0] CSR_ARM_EN      = 3'd3;
   localparam logic [2:0] CSR_ARM_SEL     = 3'd4;
   localparam logic [2:0] CSR_ARM_LEVEL   = 3'd5;
   localparam logic [2:0] CSR_ARM_HOLD    = 3'd6;
   localparam logic [2:0] CSR_RATE_WINDOW = 3'd7;

   typedef enum logic [1:0] {
      MODE_BYTE = 2'd0,
      MODE_TICK = 2'd1,
      MODE_IDLE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CHANNEL = 2'd0,
      KIND_STATS   = 2'd1,
      KIND_CRC_ERR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_SYNC = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_UNPACK,
      ST_ARM_UPD,
      ST_LOAD_CH,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic       rx_en;
      logic       unpack;
      logic [1:0] step;
      logic [3:0] chan;
      logic       arm_upd;
      logic       load_ch;
      logic       load_stats;
      logic       load_err;
      logic       last_ch;
   } cmd_type;

   typedef struct packed {
      logic       frame_end;
      logic       crc_ok;
      logic       is_chan;
      logic       is_stats;
      logic [3:0] arm_sel;
      logic       out_last;
   } status_type;

   function automatic logic [7:0] crc_update(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      for (int k = 0; k < 8; k++) begin
         r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

endpackage

/* rtl/core/rclfr_ctrl.sv */
// Controller state machine that sequences reception, unpacking and result transfers.
module rclfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  rclfr_pkg::status_type st,
   output rclfr_pkg::cmd_type    cmd
);

   rclfr_pkg::state_type state_ff, state_in;
   logic [3:0] chan_ff, chan_in;
   logic [1:0] step_ff, step_in;
   logic       arm_pass_ff, arm_pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rclfr_pkg::ST_IDLE;
         chan_ff     <= '0;
         step_ff     <= '0;
         arm_pass_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         chan_ff     <= chan_in;
         step_ff     <= step_in;
         arm_pass_ff <= arm_pass_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      chan_in     = chan_ff;
      step_in     = step_ff;
      arm_pass_in = arm_pass_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd         = '0;
      cmd.step    = step_ff;
      cmd.chan    = arm_pass_ff ? st.arm_sel : chan_ff;
      cmd.last_ch = (chan_ff == 4'(rclfr_pkg::ChannelCount - 1));
      case (state_ff)
         rclfr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.rx_en  = req_tvalid;
            if (req_tvalid && st.frame_end) begin
               state_in = rclfr_pkg::ST_DISPATCH;
            end
         end
         rclfr_pkg::ST_DISPATCH: begin
            if (!st.crc_ok) begin
               cmd.load_err = 1'b1;
               state_in     = rclfr_pkg::ST_SEND;
            end else if (st.is_stats) begin
               cmd.load_stats = 1'b1;
               state_in       = rclfr_pkg::ST_SEND;
            end else if (st.is_chan) begin
               arm_pass_in = 1'b1;
               step_in     = '0;
               state_in    = rclfr_pkg::ST_UNPACK;
            end else begin
               state_in = rclfr_pkg::ST_IDLE;
            end
         end
         rclfr_pkg::ST_UNPACK: begin
            cmd.unpack = 1'b1;
            step_in    = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = arm_pass_ff ? rclfr_pkg::ST_ARM_UPD : rclfr_pkg::ST_LOAD_CH;
            end
         end
         rclfr_pkg::ST_ARM_UPD: begin
            cmd.arm_upd = 1'b1;
            arm_pass_in = 1'b0;
            chan_in     = '0;
            step_in     = '0;
            state_in    = rclfr_pkg::ST_UNPACK;
         end
         rclfr_pkg::ST_LOAD_CH: begin
            cmd.load_ch = 1'b1;
            state_in    = rclfr_pkg::ST_SEND;
         end
         rclfr_pkg::ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (st.out_last) begin
                  state_in = rclfr_pkg::ST_IDLE;
               end else begin
                  chan_in  = chan_ff + 4'd1;
                  step_in  = '0;
                  state_in = rclfr_pkg::ST_UNPACK;
               end
            end
         end
         default: begin
            state_in = rclfr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/rclfr_dp.sv */
// Datapath with frame parsing, payload memory, channel unpacking and status registers.
module rclfr_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            mode,
   input  logic [7:0]            rx_byte,
   input  logic                  csr_we,
   input  logic [2:0]            csr_addr,
   input  logic [15:0]           csr_wdata,
   input  rclfr_pkg::cmd_type    cmd,
   output rclfr_pkg::status_type st,
   output logic [1:0]            out_kind,
   output logic [3:0]            out_index,
   output logic [10:0]           out_value,
   output logic                  out_arm,
   output logic                  out_failsafe,
   output logic [11:0]           out_rate,
   output logic [7:0]            out_quality,
   output logic [7:0]            out_rssi,
   output logic                  out_last
);

   logic        fs_en_ff;
   logic [7:0]  q_th_ff, r_th_ff;
   logic        arm_en_ff;
   logic [3:0]  arm_sel_ff;
   logic [10:0] arm_level_ff;
   logic [7:0]  arm_hold_ff;
   logic [15:0] window_ff;

   rclfr_pkg::phase_type phase_ff;
   logic [5:0]  flen_ff, bcnt_ff;
   logic [7:0]  crc_ff, type_ff, q_cap_ff, r_cap_ff;
   logic        arm_ff, fs_ff;
   logic [7:0]  persist_ff;
   logic [11:0] fiw_ff, rate_ff;
   logic [31:0] tick_ff, wstart_ff;

   logic [7:0]  mem [rclfr_pkg::BufferBytes];
   logic [7:0]  rd_ff;
   logic        rdok_ff;
   logic [23:0] acc_ff;

   logic [1:0]  kind_ff;
   logic [3:0]  idx_ff;
   logic [10:0] val_ff;
   logic [7:0]  q_ff, r_ff;
   logic        last_ff;

   logic [5:0]  bcnt_in, plen, pay_idx;
   logic [7:0]  bitpos;
   logic [10:0] ch_val;
   logic        byte_body, arm_new;
   logic [7:0]  persist_in, q_sel, r_sel;

   assign byte_body = cmd.rx_en && (mode == rclfr_pkg::MODE_BYTE) && (phase_ff == rclfr_pkg::PH_BODY);
   assign bcnt_in   = bcnt_ff + 6'd1;
   assign plen      = flen_ff - 6'd2;
   assign bitpos    = 8'(cmd.chan) * 8'(rclfr_pkg::ChannelWidth);
   assign pay_idx   = {1'b0, bitpos[7:3]} + {4'd0, cmd.step};
   assign ch_val    = 11'(acc_ff >> bitpos[2:0]);
   assign arm_new   = (ch_val > arm_level_ff);
   assign persist_in = (persist_ff != 8'hFF) ? persist_ff + 8'd1 : persist_ff;
   assign q_sel     = (flen_ff > 6'd4) ? q_cap_ff : 8'd0;
   assign r_sel     = (flen_ff > 6'd2) ? r_cap_ff : 8'd0;

   always_comb begin
      st           = '0;
      st.frame_end = byte_body && (bcnt_in >= flen_ff);
      st.crc_ok    = (crc_ff == 8'd0);
      st.is_chan   = (type_ff == rclfr_pkg::TYPE_CHANNELS);
      st.is_stats  = (type_ff == rclfr_pkg::TYPE_LINKSTATS);
      st.arm_sel   = arm_sel_ff;
      st.out_last  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (byte_body) begin
         mem[bcnt_ff] <= rx_byte;
      end
      if (cmd.unpack && cmd.step != 2'd3) begin
         rd_ff   <= mem[pay_idx + 6'd1];
         rdok_ff <= (pay_idx < plen);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.unpack && cmd.step != 2'd0) begin
         case (cmd.step)
            2'd1:    acc_ff[7:0]   <= rdok_ff ? rd_ff : 8'd0;
            2'd2:    acc_ff[15:8]  <= rdok_ff ? rd_ff : 8'd0;
            default: acc_ff[23:16] <= rdok_ff ? rd_ff : 8'd0;
         endcase
      end
      if (byte_body) begin
         if (bcnt_ff == 6'd0) type_ff  <= rx_byte;
         if (bcnt_ff == 6'd1) r_cap_ff <= rx_byte;
         if (bcnt_ff == 6'd3) q_cap_ff <= rx_byte;
      end
      if (cmd.load_err || cmd.load_stats || cmd.load_ch) begin
         kind_ff <= cmd.load_ch ? rclfr_pkg::KIND_CHANNEL :
                    cmd.load_stats ? rclfr_pkg::KIND_STATS : rclfr_pkg::KIND_CRC_ERR;
         idx_ff  <= cmd.load_ch ? cmd.chan : 4'd0;
         val_ff  <= cmd.load_ch ? ch_val : 11'd0;
         q_ff    <= cmd.load_stats ? q_sel : 8'd0;
         r_ff    <= cmd.load_stats ? r_sel : 8'd0;
         last_ff <= cmd.load_ch ? cmd.last_ch : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_en_ff     <= 1'b1;
         q_th_ff      <= 8'd50;
         r_th_ff      <= 8'd100;
         arm_en_ff    <= 1'b1;
         arm_sel_ff   <= 4'd4;
         arm_level_ff <= 11'd1500;
         arm_hold_ff  <= 8'd3;
         window_ff    <= 16'd1000;
      end else if (csr_we) begin
         case (csr_addr)
            rclfr_pkg::CSR_FAILSAFE_EN: fs_en_ff     <= csr_wdata[0];
            rclfr_pkg::CSR_QUALITY_TH:  q_th_ff      <= csr_wdata[7:0];
            rclfr_pkg::CSR_RSSI_TH:     r_th_ff      <= csr_wdata[7:0];
            rclfr_pkg::CSR_ARM_EN:      arm_en_ff    <= csr_wdata[0];
            rclfr_pkg::CSR_ARM_SEL:     arm_sel_ff   <= csr_wdata[3:0];
            rclfr_pkg::CSR_ARM_LEVEL:   arm_level_ff <= csr_wdata[10:0];
            rclfr_pkg::CSR_ARM_HOLD:    arm_hold_ff  <= csr_wdata[7:0];
            rclfr_pkg::CSR_RATE_WINDOW: window_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rclfr_pkg::PH_SYNC;
         flen_ff    <= '0;
         bcnt_ff    <= '0;
         crc_ff     <= '0;
         arm_ff     <= 1'b0;
         persist_ff <= '0;
         fs_ff      <= 1'b0;
         fiw_ff     <= '0;
         rate_ff    <= '0;
         tick_ff    <= '0;
         wstart_ff  <= '0;
      end else begin
         if (cmd.rx_en) begin
            case (mode)
               rclfr_pkg::MODE_TICK: tick_ff <= tick_ff + 32'd1;
               rclfr_pkg::MODE_IDLE: begin
                  phase_ff <= rclfr_pkg::PH_SYNC;
                  bcnt_ff  <= '0;
                  crc_ff   <= '0;
               end
               rclfr_pkg::MODE_BYTE: begin
                  case (phase_ff)
                     rclfr_pkg::PH_SYNC: begin
                        if (rx_byte == rclfr_pkg::SYNC_A || rx_byte == rclfr_pkg::SYNC_B) begin
                           phase_ff <= rclfr_pkg::PH_LEN;
                        end
                     end
                     rclfr_pkg::PH_LEN: begin
                        if (rx_byte >= rclfr_pkg::LEN_MIN && rx_byte <= rclfr_pkg::LEN_MAX) begin
                           flen_ff  <= rx_byte[5:0];
                           bcnt_ff  <= '0;
                           crc_ff   <= '0;
                           phase_ff <= rclfr_pkg::PH_BODY;
                        end else begin
                           phase_ff <= rclfr_pkg::PH_SYNC;
                        end
                     end
                     default: begin
                        crc_ff <= rclfr_pkg::crc_update(crc_ff, rx_byte);
                        if (bcnt_in >= flen_ff) begin
                           phase_ff <= rclfr_pkg::PH_SYNC;
                           bcnt_ff  <= '0;
                        end else begin
                           bcnt_ff <= bcnt_in;
                        end
                     end
                  endcase
               end
               default: ;
            endcase
         end
         if (cmd.load_stats && fs_en_ff && (q_sel < q_th_ff || r_sel > r_th_ff)) begin
            fs_ff <= 1'b1;
         end
         if (cmd.arm_upd) begin
            if (arm_en_ff) begin
               if (arm_new != arm_ff) begin
                  persist_ff <= persist_in;
                  if (persist_in > arm_hold_ff) arm_ff <= arm_new;
               end else begin
                  persist_ff <= '0;
               end
            end
            if ((tick_ff - wstart_ff) >= {16'd0, window_ff}) begin
               rate_ff   <= fiw_ff;
               fiw_ff    <= 12'd1;
               wstart_ff <= tick_ff;
            end else if (fiw_ff != 12'hFFF) begin
               fiw_ff <= fiw_ff + 12'd1;
            end
         end
      end
   end

   assign out_kind     = kind_ff;
   assign out_index    = idx_ff;
   assign out_value    = val_ff;
   assign out_arm      = arm_ff;
   assign out_failsafe = fs_ff;
   assign out_rate     = rate_ff;
   assign out_quality  = q_ff;
   assign out_rssi     = r_ff;
   assign out_last     = last_ff;

endmodule

/* rtl/core/rc_link_frame_receiver.sv */
// Top level of the radio-control link frame receiver.
// An input transfer (byte, tick or idle reset) that causes no result leaves the receiver idle.
// A frame end with a CRC error or a link-statistics frame gives one result, which the
// dispatch state loads into the output registers. A channels frame is unpacked from the
// payload memory, one registered byte read per cycle, in one pass for the arm channel, then
// one pass per reported channel, giving sixteen results. No input is taken while a frame's
// results are being sent.
module rc_link_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // channel_index[3:0], channel_value[14:4], arm_flag[15],
                                    // failsafe_flag[16], packet_rate[28:17],
                                    // uplink_quality[36:29], uplink_rssi[44:37], zero[47:45]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   rclfr_pkg::cmd_type    cmd;
   rclfr_pkg::status_type st;
   logic [3:0]  o_idx;
   logic [10:0] o_val;
   logic        o_arm, o_fs;
   logic [11:0] o_rate;
   logic [7:0]  o_q, o_r;

   rclfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   rclfr_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .mode         (req_tuser),
      .rx_byte      (req_tdata),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .st           (st),
      .out_kind     (rsp_tuser),
      .out_index    (o_idx),
      .out_value    (o_val),
      .out_arm      (o_arm),
      .out_failsafe (o_fs),
      .out_rate     (o_rate),
      .out_quality  (o_q),
      .out_rssi     (o_r),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, o_r, o_q, o_rate, o_fs, o_arm, o_val, o_idx};

endmodule

/* rtl/core/rclfr_checker.sv */
// Port-level checker of the radio-control link frame receiver, bound to the top level.
module rclfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result valid dropped before transfer");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rclfr_pkg::KIND_CHANNEL |-> rsp_tlast && rsp_tdata[14:0] == 15'd0)
      else $error("non-channel result without last or with channel fields");

   a_failsafe_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata[16] ##1 rsp_tvalid |-> rsp_tdata[16])
      else $error("failsafe flag cleared");

endmodule

bind rc_link_frame_receiver rclfr_checker u_rclfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
